@@ rtl/rhc_pkg.sv @@
// Shared types, constants and helper functions for the rolling hash chunk
// boundary detector. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rhc_pkg;

    localparam int WINDOW_DEF = 16;
    localparam int HASH_BASE  = 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_MODULUS_BITS = 2'd0;
    localparam t_cfg_idx CFG_TARGET_VALUE = 2'd1;
    localparam t_cfg_idx CFG_MIN_START    = 2'd2;

    localparam logic [5:0]  MODULUS_BITS_RST = 6'd8;
    localparam logic [31:0] TARGET_VALUE_RST = 32'd0;
    localparam logic [15:0] MIN_START_RST    = 16'd17;

    // Shift control handed to every window cell and to the hash unit
    typedef struct packed {
        logic advance;
        logic clear;
    } t_roll_ctl;

    // Hash and position of one byte as produced by the hash unit
    typedef struct packed {
        logic [31:0] hash;
        logic [31:0] pos;
    } t_roll;

    // Request held between the hash unit and the compare stage
    typedef struct packed {
        logic [31:0] hash;
        logic [31:0] pos;
        logic        last;
    } t_stage;

    // HASH_BASE^n modulo 2^32, evaluated at elaboration
    function automatic logic [31:0] base_power(input int n);
        logic [31:0] p;
        p = 32'd1;
        for (int k = 0; k < n; k++) begin
            p = p * 32'(HASH_BASE);
        end
        return p;
    endfunction

endpackage

`default_nettype wire

@@ rtl/rhc_in_if.sv @@
// Input byte channel of the chunk boundary detector.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface rhc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output first_byte,
                    output last_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte,
                    input last_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/rhc_out_if.sv @@
// Result channel of the chunk boundary detector.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface rhc_out_if;
    logic        valid;
    logic        ready;
    logic        boundary;
    logic [31:0] boundary_start;
    logic        end_of_buffer;

    modport source (output valid, output boundary, output boundary_start,
                    output end_of_buffer, input ready);
    modport sink   (input valid, input boundary, input boundary_start,
                    input end_of_buffer, output ready);
endinterface

`default_nettype wire

@@ rtl/rhc_cfg_if.sv @@
// Register write channel of the chunk boundary detector.
// Depends on rhc_pkg for the index and data widths.
`timescale 1ns / 1ps
`default_nettype none

interface rhc_cfg_if;
    import rhc_pkg::*;
    logic                  valid;
    logic                  ready;
    t_cfg_idx              index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/rhc_cell.sv @@
// One byte cell of the window shift chain: takes its neighbor's byte on
// every advance, or zero on a buffer start. Depends on rhc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rhc_cell
    import rhc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_roll_ctl i_ctl,
    input  wire logic [7:0] i_data,
    output logic [7:0]     o_data
);

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    always_comb begin
        n_byte = r_byte;
        if (i_ctl.advance) begin
            n_byte = i_ctl.clear ? 8'd0 : i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= 8'd0;
        end else begin
            r_byte <= n_byte;
        end
    end

    assign o_data = r_byte;

endmodule

`default_nettype wire

@@ rtl/rhc_roll.sv @@
// Rolling hash and saturating byte position. Rolls the hash by the entering
// and leaving bytes on each advance. Depends on rhc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rhc_roll
    import rhc_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_roll_ctl  i_ctl,
    input  wire logic [7:0] i_data_byte,
    input  wire logic [7:0] i_oldest,
    output t_roll           o_roll
);

    // weight of the leaving byte once the window has been multiplied by 3
    localparam logic [31:0] LEAVE_POW = base_power(WINDOW + 1);

    logic [31:0] r_hash;
    logic [31:0] r_pos;
    logic [31:0] n_hash;
    logic [31:0] n_pos;
    logic [31:0] base_hash;
    logic [31:0] base_pos;
    logic [7:0]  leave_byte;
    logic [31:0] leave_term;

    always_comb begin
        base_hash  = i_ctl.clear ? 32'd0 : r_hash;
        base_pos   = i_ctl.clear ? 32'd0 : r_pos;
        leave_byte = i_ctl.clear ? 8'd0 : i_oldest;
        leave_term = 32'(leave_byte) * LEAVE_POW;
        n_hash = (base_hash << 1) + base_hash - leave_term
               + ({24'd0, i_data_byte} << 1) + {24'd0, i_data_byte};
        // saturate at the top of the range
        n_pos  = (base_pos == '1) ? base_pos : base_pos + 32'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= 32'd0;
            r_pos  <= 32'd0;
        end else if (i_ctl.advance) begin
            r_hash <= n_hash;
            r_pos  <= n_pos;
        end
    end

    assign o_roll.hash = n_hash;
    assign o_roll.pos  = base_pos;

endmodule

`default_nettype wire

@@ rtl/rhc_match.sv @@
// Boundary compare: window start, minimum start check and masked hash
// compare against the target. Depends on rhc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rhc_match
    import rhc_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  wire t_stage      i_stage,
    input  wire logic [5:0]  i_modulus_bits,
    input  wire logic [31:0] i_target_value,
    input  wire logic [15:0] i_min_start,
    output logic             o_boundary,
    output logic [31:0]      o_boundary_start
);

    localparam logic [31:0] SPAN = 32'(WINDOW - 1);

    logic        full;
    logic [31:0] start;
    logic [31:0] mask;

    always_comb begin
        full  = i_stage.pos >= SPAN;
        start = full ? i_stage.pos - SPAN : 32'd0;
        // six-bit count: 32 and above select the whole hash
        if (i_modulus_bits[5]) begin
            mask = '1;
        end else begin
            mask = (32'd1 << i_modulus_bits[4:0]) - 32'd1;
        end
        o_boundary = full && (start >= {16'd0, i_min_start})
                   && ((i_stage.hash & mask) == i_target_value);
        o_boundary_start = start;
    end

endmodule

`default_nettype wire

@@ rtl/rolling_hash_chunk_boundary.sv @@
// Content-defined chunk boundary detector, top level: window cell chain,
// rolling hash unit, compare stage, register file. Depends on rhc_pkg,
// the rhc_*_if interfaces, rhc_cell, rhc_roll and rhc_match.
`timescale 1ns / 1ps
`default_nettype none

// Takes one byte per clock while the result channel is not stalled and returns
// one result per byte, registered in the compare stage and then in the output
// register. The window is a chain of WINDOW byte cells that shift on every
// accepted byte; the hash is rolled with constant multiplies only, so the hash
// register loop sets the rate of one byte per cycle. A compare stage and an output
// register follow, each able to hold a request while the stage after it
// stalls. Registers are written through the config channel, which is always
// ready; write them only while no result is outstanding.
module rolling_hash_chunk_boundary
    import rhc_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rhc_in_if.sink     i_in,
    rhc_out_if.source  o_out,
    rhc_cfg_if.sink    i_cfg
);

    logic       [5:0]  r_modulus_bits;
    logic       [31:0] r_target_value;
    logic       [15:0] r_min_start;

    logic              accept;
    logic              out_take;
    t_roll_ctl         roll_ctl;
    t_roll_ctl         tail_ctl;
    t_roll             roll;
    logic [7:0]        w_win [WINDOW];

    logic              r_s1v;
    t_stage            r_s1;
    logic              r_ov;
    logic              r_o_boundary;
    logic [31:0]       r_o_start;
    logic              r_o_eob;
    logic              m_boundary;
    logic [31:0]       m_start;

    // register file
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus_bits <= MODULUS_BITS_RST;
            r_target_value <= TARGET_VALUE_RST;
            r_min_start    <= MIN_START_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_MODULUS_BITS: r_modulus_bits <= i_cfg.data[5:0];
                CFG_TARGET_VALUE: r_target_value <= i_cfg.data[31:0];
                CFG_MIN_START:    r_min_start    <= i_cfg.data[15:0];
                default: ;
            endcase
        end
    end

    // handshake
    assign out_take   = !r_ov || o_out.ready;
    assign i_in.ready = !r_s1v || out_take;
    assign accept     = i_in.valid && i_in.ready;

    assign roll_ctl.advance = accept;
    assign roll_ctl.clear   = i_in.first_byte;
    // the newest cell always loads the incoming byte, even on a buffer start
    assign tail_ctl.advance = accept;
    assign tail_ctl.clear   = 1'b0;

    // window cell chain, oldest byte in cell 0
    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        if (g == WINDOW - 1) begin : g_tail
            rhc_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (tail_ctl),
                .i_data  (i_in.data_byte),
                .o_data  (w_win[g])
            );
        end else begin : g_body
            rhc_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (roll_ctl),
                .i_data  (w_win[g+1]),
                .o_data  (w_win[g])
            );
        end
    end

    rhc_roll #(
        .WINDOW (WINDOW)
    ) u_roll (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (roll_ctl),
        .i_data_byte (i_in.data_byte),
        .i_oldest    (w_win[0]),
        .o_roll      (roll)
    );

    // compare stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1v <= 1'b0;
        end else if (accept) begin
            r_s1v <= 1'b1;
        end else if (out_take) begin
            r_s1v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.hash <= roll.hash;
            r_s1.pos  <= roll.pos;
            r_s1.last <= i_in.last_byte;
        end
    end

    rhc_match #(
        .WINDOW (WINDOW)
    ) u_match (
        .i_stage          (r_s1),
        .i_modulus_bits   (r_modulus_bits),
        .i_target_value   (r_target_value),
        .i_min_start      (r_min_start),
        .o_boundary       (m_boundary),
        .o_boundary_start (m_start)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_s1v && out_take) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1v && out_take) begin
            r_o_boundary <= m_boundary;
            r_o_start    <= m_start;
            r_o_eob      <= r_s1.last;
        end
    end

    assign o_out.valid          = r_ov;
    assign o_out.boundary       = r_o_boundary;
    assign o_out.boundary_start = r_o_start;
    assign o_out.end_of_buffer  = r_o_eob;

    // checks
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_ov && !r_s1v)
        else $error("pipeline not empty after reset");

    a_boundary_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_o_boundary |-> r_o_start >= {16'd0, r_min_start})
        else $error("boundary reported below minimum start");

    a_first_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.first_byte |=> r_s1v && r_s1.pos == 32'd0)
        else $error("buffer start did not restart position");

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// Testbench for rolling_hash_chunk_boundary: byte streams with random gaps and
// stalls, each result predicted from a local window/hash model and checked per field.
// Depends on rhc_pkg and the rhc_in_if, rhc_out_if and rhc_cfg_if interfaces.
`timescale 1ns / 1ps

module tb_top;
    import rhc_pkg::*;

    localparam int WIN          = WINDOW_DEF;
    localparam int MAX_IDLE     = 11;
    localparam int QUIET_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 8;
    localparam int PHASE_BYTES  = 45;
    localparam int PHASE_COUNT  = 9;
    // 3^(WIN+1) for a 16-byte window: weight of the leaving byte after the times-3 step
    localparam logic [31:0] LEAVE_WEIGHT = 32'd129140163;

    typedef struct packed {
        logic        boundary;
        logic [31:0] start;
        logic        end_of_buffer;
    } t_chunk_result;

    logic i_clk;
    logic i_rst_n;

    rhc_in_if  in_if ();
    rhc_out_if out_if ();
    rhc_cfg_if cfg_if ();

    rolling_hash_chunk_boundary dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Predicted block state and register copies
    logic [7:0]  window_q [WIN];
    logic [31:0] hash_q;
    logic [31:0] pos_q;
    logic [5:0]  mod_bits_q;
    logic [31:0] target_q;
    logic [15:0] min_start_q;

    t_chunk_result expected_chunks [$];

    int mismatches;
    int bytes_sent;
    int results_seen;
    int boundaries_seen;
    int reg_writes;
    int quiet_cycles;
    bit src_idle_on;
    bit sink_idle_on;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Shift one byte into the predicted window and return the result it closes
    function automatic t_chunk_result roll_in_byte(input logic [7:0] b, input logic first,
                                                   input logic last);
        t_chunk_result r;
        logic [7:0]    oldest;
        logic [31:0]   mask;
        logic [31:0]   pos;
        int            k;
        if (first) begin
            for (k = 0; k < WIN; k++) window_q[k] = 8'd0;
            hash_q = 32'd0;
            pos_q  = 32'd0;
        end
        oldest = window_q[0];
        for (k = 0; k < WIN - 1; k++) window_q[k] = window_q[k + 1];
        window_q[WIN - 1] = b;
        hash_q = hash_q * 32'd3 - {24'd0, oldest} * LEAVE_WEIGHT + {24'd0, b} * 32'd3;
        pos = pos_q;
        if (pos_q != 32'hFFFF_FFFF) pos_q = pos_q + 32'd1;
        if (mod_bits_q == 6'd0) mask = 32'd0;
        else if (mod_bits_q >= 6'd32) mask = 32'hFFFF_FFFF;
        else mask = (32'd1 << mod_bits_q) - 32'd1;
        r.boundary      = 1'b0;
        r.start         = 32'd0;
        r.end_of_buffer = last;
        if (pos >= 32'(WIN - 1)) begin
            r.start    = pos - 32'(WIN - 1);
            r.boundary = (r.start >= {16'd0, min_start_q}) && ((hash_q & mask) == target_q);
        end
        return r;
    endfunction

    // Hold valid high across back-to-back requests; drop it only before a gap
    task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
        int gap;
        gap = src_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.data_byte  <= b;
        in_if.first_byte <= first;
        in_if.last_byte  <= last;
        do @(posedge i_clk); while (!in_if.ready);
        expected_chunks.push_back(roll_in_byte(b, first, last));
        bytes_sent++;
    endtask

    task automatic wait_results_drained();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (expected_chunks.size() != 0);
    endtask

    // Write all three registers once the block is idle; upper data bits are don't-care
    task automatic write_config(input logic [5:0] mod_bits, input logic [31:0] target,
                                input logic [15:0] min_start);
        t_cfg_idx    idx  [3];
        logic [31:0] data [3];
        int          k;
        idx[0]  = CFG_MODULUS_BITS;
        idx[1]  = CFG_TARGET_VALUE;
        idx[2]  = CFG_MIN_START;
        data[0] = ($urandom() & 32'hFFFF_FFC0) | {26'd0, mod_bits};
        data[1] = target;
        data[2] = ($urandom() & 32'hFFFF_0000) | {16'd0, min_start};
        wait_results_drained();
        for (k = 0; k < 3; k++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= idx[k];
            cfg_if.data  <= data[k];
            do @(posedge i_clk); while (!cfg_if.ready);
            reg_writes++;
        end
        cfg_if.valid <= 1'b0;
        mod_bits_q  = mod_bits;
        target_q    = target;
        min_start_q = min_start;
    endtask

    // Bytes straight out of reset, no new-buffer flag: stream starts from cleared state
    task automatic test_reset_state();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h80, 1'b0, 1'b0);
        send_byte(8'h7F, 1'b0, 1'b1);
    endtask

    // Empty mask, zero target, zero minimum: every full window is a boundary.
    // Covers the not-yet-full window, a new buffer, and bytes continuing past last.
    task automatic test_window_fill();
        int k;
        write_config(6'd0, 32'd0, 16'd0);
        for (k = 0; k < WIN + 1; k++)
            send_byte((k % 2) ? 8'h00 : 8'hFF, k == 0, k == WIN);
        send_byte(8'($urandom()), 1'b0, 1'b0);
        send_byte(8'($urandom()), 1'b0, 1'b1);
    endtask

    // Mostly well-formed buffers with random content under a series of settings
    task automatic test_random_streams();
        int p;
        int sent;
        int len;
        int k;
        bit no_first;
        for (p = 0; p < PHASE_COUNT; p++) begin
            unique case (p)
                0: write_config(6'd8, 32'd0, 16'd17);
                1: write_config(6'd1, 32'($urandom_range(0, 1)), 16'd0);
                2: write_config(6'd3, 32'($urandom_range(0, 7)), 16'($urandom_range(0, 40)));
                3: write_config(6'd0, 32'd0, 16'hFFFF);
                4: write_config(6'd2, 32'hFFFF_FFFC | 32'($urandom_range(0, 3)), 16'd0);
                5: write_config(6'd63, $urandom(), 16'd0);
                6: write_config(6'd32, 32'hFFFF_FFFF, 16'd5);
                7: write_config(6'd33, 32'd0, 16'($urandom_range(0, 20)));
                default: write_config(6'd4, 32'($urandom_range(0, 15)),
                                      16'($urandom_range(0, 30)));
            endcase
            sent = 0;
            while (sent < PHASE_BYTES) begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, WIN - 1)
                                                  : $urandom_range(WIN, 50);
                if (len > PHASE_BYTES - sent) len = PHASE_BYTES - sent;
                no_first     = ($urandom_range(0, 9) == 0);
                src_idle_on  = ($urandom_range(0, 3) != 0);
                sink_idle_on = ($urandom_range(0, 3) != 0);
                for (k = 0; k < len; k++) begin
                    if ($urandom_range(0, 39) == 0) wait_results_drained();
                    send_byte(8'($urandom()),
                              (k == 0 && !no_first) || ($urandom_range(0, 49) == 0),
                              (k == len - 1) || ($urandom_range(0, 49) == 0));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        in_if.valid      <= 1'b0;
        in_if.data_byte  <= 8'd0;
        in_if.first_byte <= 1'b0;
        in_if.last_byte  <= 1'b0;
        cfg_if.valid     <= 1'b0;
        cfg_if.index     <= CFG_MODULUS_BITS;
        cfg_if.data      <= 32'd0;
        i_rst_n          <= 1'b0;
        for (int k = 0; k < WIN; k++) window_q[k] = 8'd0;
        hash_q      = 32'd0;
        pos_q       = 32'd0;
        mod_bits_q  = MODULUS_BITS_RST;
        target_q    = TARGET_VALUE_RST;
        min_start_q = MIN_START_RST;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_window_fill();
        test_random_streams();

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_chunks.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_chunks.size());
            mismatches++;
        end
        $display("Sent %0d bytes across %0d register writes (mask widths 0..63, edge targets).",
                 bytes_sent, reg_writes);
        $display("Checked %0d results, %0d of them boundaries.", results_seen, boundaries_seen);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Result sink: random stall before each request, sometimes none
    initial begin
        int stall;
        out_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = sink_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_chunk_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            results_seen++;
            if (out_if.boundary) boundaries_seen++;
            if (expected_chunks.size() == 0) begin
                $display("%0t: unexpected result boundary=%0d start=%0d end_of_buffer=%0d",
                         $time, out_if.boundary, out_if.boundary_start, out_if.end_of_buffer);
                mismatches++;
            end else begin
                want = expected_chunks.pop_front();
                if (out_if.boundary !== want.boundary) begin
                    $display("%0t: boundary expected %0d actual %0d",
                             $time, want.boundary, out_if.boundary);
                    mismatches++;
                end
                if (out_if.boundary_start !== want.start) begin
                    $display("%0t: boundary_start expected %0d actual %0d",
                             $time, want.start, out_if.boundary_start);
                    mismatches++;
                end
                if (out_if.end_of_buffer !== want.end_of_buffer) begin
                    $display("%0t: end_of_buffer expected %0d actual %0d",
                             $time, want.end_of_buffer, out_if.end_of_buffer);
                    mismatches++;
                end
            end
        end
    end

    // Count cycles with no request moving on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no request accepted for %0d cycles", $time, QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

@@ files.f @@
rtl/rhc_pkg.sv
rtl/rhc_in_if.sv
rtl/rhc_out_if.sv
rtl/rhc_cfg_if.sv
rtl/rhc_cell.sv
rtl/rhc_roll.sv
rtl/rhc_match.sv
rtl/rolling_hash_chunk_boundary.sv
test/tb_top.sv
